FILE: src/ade_pkg.sv
// Shared constants for the attack/decay envelope block: curve resolution,
// level format, register and phase codes, and the 2^(2^-i) root table.
// No dependencies.
package ade_pkg;

   localparam int unsigned CURVE_TABLE_DEPTH = 256;
   localparam int unsigned DEPTH_LOG2 = $clog2(CURVE_TABLE_DEPTH);
   localparam int unsigned LEVEL_BITS = 16;
   localparam int unsigned N_BITS = $clog2(DEPTH_LOG2);

   // log2(e) in Q16 and the bias that centers shape 128 on exponent 1.0
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam int unsigned EXP_OFFSET = (3 << 16) - 189096;

   localparam logic [2:0] CSR_PEAK_LEVEL = 3'd0;
   localparam logic [2:0] CSR_ATTACK_MS = 3'd1;
   localparam logic [2:0] CSR_ATTACK_SHAPE = 3'd2;
   localparam logic [2:0] CSR_DECAY_MS = 3'd3;
   localparam logic [2:0] CSR_DECAY_SHAPE = 3'd4;

   localparam logic [1:0] PH_REST = 2'd0;
   localparam logic [1:0] PH_ATTACK = 2'd1;
   localparam logic [1:0] PH_HOLD = 2'd2;
   localparam logic [1:0] PH_DECAY = 2'd3;

   // 2^(2^-(i+1)) in Q30
   function automatic logic [30:0] exp2_root(input logic [3:0] idx);
      logic [30:0] r;
      unique case (idx)
         4'd0: r = 31'd1518500250;
         4'd1: r = 31'd1276901417;
         4'd2: r = 31'd1170923762;
         4'd3: r = 31'd1121280439;
         4'd4: r = 31'd1097253708;
         4'd5: r = 31'd1085434104;
         4'd6: r = 31'd1079572136;
         4'd7: r = 31'd1076653033;
         4'd8: r = 31'd1075196443;
         4'd9: r = 31'd1074468888;
         4'd10: r = 31'd1074105294;
         4'd11: r = 31'd1073923544;
         4'd12: r = 31'd1073832680;
         4'd13: r = 31'd1073787251;
         4'd14: r = 31'd1073764537;
         4'd15: r = 31'd1073753181;
      endcase
      return r;
   endfunction

endpackage

FILE: src/attack_decay_envelope_top.sv
// Attack/decay envelope generator: one update word in, one level word out.
// Depends on ade_pkg for constants and the exp2 root table.
//
// Usage:
//  - Request channel (req_valid/req_ready) carries one update word: the gate
//    level and the current time in ms. A rising gate starts the attack, a
//    falling gate starts the decay; both record the time.
//  - Response channel (rsp_valid/rsp_ready) returns one word per update: the
//    envelope level (Q0.16) and the phase code.
//  - Register port (csr_valid/csr_ready, csr_index, csr_data) is always
//    ready; indexes beyond the decay shape are dropped.
// Timing:
//  - One update at a time. A finished phase (hold or rest) goes straight to
//    the output step and a zero phase time goes through the blend alone. An
//    end point or a linear shape takes a 9-step bit-serial divider for the
//    curve position, a classify step and a blend. A curved shape adds passes
//    of 16 steps over one shared 32x32 multiplier for the exponent, log2 of
//    the position and exp2 of the product; the last pass is skipped when the
//    exponent product has no fraction.
//  - The result sits in an output register, so the next update is taken
//    while a result still waits; the block stalls only when it has a second
//    result ready and the receiver has not taken the first.
// Reset: synchronous, active high; registers return to their defaults and
//    the envelope state (gate, start time, end values, level) clears to zero.
module attack_decay_envelope_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_gate,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_cv_level,
   output logic [1:0]  rsp_phase,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned DL = ade_pkg::DEPTH_LOG2;
   localparam int unsigned LB = ade_pkg::LEVEL_BITS;
   localparam int unsigned NB = ade_pkg::N_BITS;
   localparam logic [LB:0] ONE = (LB+1)'(1) << LB;
   localparam logic [31:0] Q30_ONE = 32'd1 << 30;
   localparam logic [19:0] LOG_DEPTH = 20'(DL) << 16;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_CLASS, S_EXP, S_LOGI, S_LOG, S_PMUL, S_SHIFT, S_BLEND, S_DONE
   } state_type;

   state_type   state_ff;
   logic [3:0]  cnt_ff;
   logic [15:0] peak_ff, attack_ms_ff, decay_ms_ff;
   logic [8:0]  attack_shape_ff, decay_shape_ff;
   logic        gate_active_ff;
   logic [31:0] start_ff;
   logic [15:0] attack_end_ff, decay_end_ff, out_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_cv_level_ff;
   logic [1:0]  rsp_phase_ff;
   logic        attack_ff, curve_pass_ff;
   logic [1:0]  ph_ff;
   logic [15:0] tms_ff;
   logic [8:0]  shape_ff;
   logic [16:0] rem_ff;
   logic [DL:0] k_ff;
   logic [15:0] efrac_ff;
   logic [2:0]  eip_ff;
   logic [31:0] acc_ff;
   logic [19:0] e_ff, lres_ff;
   logic [6:0]  sh_ff;
   logic [LB:0] c_ff;

   // intake
   logic [31:0] start_in, elapsed_in;
   logic [15:0] tsel_in;
   logic [8:0]  ssel_raw, ssel_in;
   // shared multiplier
   logic [31:0] mul_a_in, mul_b_in;
   logic [63:0] mul_p;
   // datapath helpers
   logic        div_ge_in;
   logic [16:0] div_rem_in;
   logic [25:0] shape_prod_in;
   logic [19:0] y_in, lg_in;
   logic [NB-1:0] n_in;
   logic [31:0] m_in, sq_in, shifted_in;
   logic [23:0] p_in;
   logic [6:0]  pn_in;
   logic [15:0] diff_in, d_in, out_in;
   logic        up_in;
   logic        rsp_load_in;

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cv_level = rsp_cv_level_ff;
   assign rsp_phase    = rsp_phase_ff;

   // load the output register when a result is done and the register is free
   assign rsp_load_in  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      start_in   = (req_gate != gate_active_ff) ? req_now_ms : start_ff;
      elapsed_in = req_now_ms - start_in;
      tsel_in    = req_gate ? attack_ms_ff : decay_ms_ff;
      ssel_raw   = req_gate ? attack_shape_ff : decay_shape_ff;
      // clamp shape to 256
      ssel_in    = (ssel_raw[8] && (ssel_raw[7:0] != 8'd0)) ? 9'd256 : ssel_raw;
   end

   // divider step: one quotient bit a cycle
   always_comb begin
      div_ge_in  = (rem_ff >= {1'b0, tms_ff});
      div_rem_in = div_ge_in ? (rem_ff - {1'b0, tms_ff}) : rem_ff;
   end

   always_comb begin
      shape_prod_in = 26'(shape_ff) * 26'(ade_pkg::LOG2E_Q16);
      y_in = 20'(shape_prod_in >> 6) + 20'(ade_pkg::EXP_OFFSET);
      n_in = '0;
      for (int i = 0; i < DL; i++) begin
         if (k_ff[i]) n_in = NB'(i);
      end
      m_in = 32'(k_ff) << (30 - 32'(n_in));
      lg_in = LOG_DEPTH - lres_ff;
   end

   always_comb begin
      unique case (state_ff)
         S_EXP: begin
            mul_a_in = acc_ff;
            mul_b_in = {1'b0, ade_pkg::exp2_root(cnt_ff)};
         end
         S_LOG: begin
            mul_a_in = acc_ff;
            mul_b_in = acc_ff;
         end
         S_PMUL: begin
            mul_a_in = 32'(e_ff);
            mul_b_in = 32'(lg_in);
         end
         S_BLEND: begin
            mul_a_in = 32'(diff_in);
            mul_b_in = 32'(c_ff);
         end
         default: begin
            mul_a_in = '0;
            mul_b_in = '0;
         end
      endcase
      mul_p = 64'(mul_a_in) * 64'(mul_b_in);
   end

   always_comb begin
      sq_in = mul_p[61:30];
      p_in  = mul_p[39:16];
      pn_in = (p_in[23:16] > 8'd64) ? 7'd64 : p_in[22:16];
      shifted_in = (sh_ff >= 7'd64) ? 32'd0 : (acc_ff >> sh_ff);
   end

   // blend toward the segment target, truncating toward the start value
   always_comb begin
      up_in = (peak_ff >= decay_end_ff);
      if (attack_ff) begin
         diff_in = up_in ? (peak_ff - decay_end_ff) : (decay_end_ff - peak_ff);
      end else begin
         diff_in = attack_end_ff;
      end
      d_in = mul_p[LB+15:LB];
      if (attack_ff) begin
         out_in = up_in ? (decay_end_ff + d_in) : (decay_end_ff - d_in);
      end else begin
         out_in = attack_end_ff - d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cnt_ff          <= '0;
         peak_ff         <= 16'd65535;
         attack_ms_ff    <= 16'd100;
         attack_shape_ff <= 9'd128;
         decay_ms_ff     <= 16'd100;
         decay_shape_ff  <= 9'd128;
         gate_active_ff  <= 1'b0;
         start_ff        <= '0;
         attack_end_ff   <= '0;
         decay_end_ff    <= '0;
         out_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         curve_pass_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ade_pkg::CSR_PEAK_LEVEL:   peak_ff <= csr_data;
               ade_pkg::CSR_ATTACK_MS:    attack_ms_ff <= csr_data;
               ade_pkg::CSR_ATTACK_SHAPE: attack_shape_ff <= csr_data[8:0];
               ade_pkg::CSR_DECAY_MS:     decay_ms_ff <= csr_data;
               ade_pkg::CSR_DECAY_SHAPE:  decay_shape_ff <= csr_data[8:0];
               default: ;
            endcase
         end

         if (rsp_load_in) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  gate_active_ff <= req_gate;
                  start_ff       <= start_in;
                  attack_ff      <= req_gate;
                  tms_ff         <= tsel_in;
                  shape_ff       <= ssel_in;
                  if (elapsed_in > 32'(tsel_in)) begin
                     // phase over: hold level and end values
                     ph_ff    <= req_gate ? ade_pkg::PH_HOLD : ade_pkg::PH_REST;
                     state_ff <= S_DONE;
                  end else begin
                     ph_ff <= req_gate ? ade_pkg::PH_ATTACK : ade_pkg::PH_DECAY;
                     if (tsel_in == 16'd0) begin
                        c_ff     <= ONE;
                        state_ff <= S_BLEND;
                     end else begin
                        rem_ff   <= elapsed_in[16:0];
                        k_ff     <= '0;
                        cnt_ff   <= 4'(DL);
                        state_ff <= S_DIV;
                     end
                  end
               end
            end
            S_DIV: begin
               rem_ff <= {div_rem_in[15:0], 1'b0};
               k_ff   <= {k_ff[DL-1:0], div_ge_in};
               cnt_ff <= cnt_ff - 4'd1;
               if (cnt_ff == 4'd0) state_ff <= S_CLASS;
            end
            S_CLASS: begin
               priority if (k_ff[DL]) begin
                  c_ff     <= ONE;
                  state_ff <= S_BLEND;
               end else if (k_ff == '0) begin
                  c_ff     <= '0;
                  state_ff <= S_BLEND;
               end else if (shape_ff == 9'd128) begin
                  c_ff     <= (LB+1)'(k_ff) << (LB - DL);
                  state_ff <= S_BLEND;
               end else begin
                  efrac_ff      <= y_in[15:0];
                  eip_ff        <= y_in[18:16];
                  acc_ff        <= Q30_ONE;
                  cnt_ff        <= '0;
                  curve_pass_ff <= 1'b0;
                  state_ff      <= S_EXP;
               end
            end
            S_EXP: begin
               if (efrac_ff[~cnt_ff]) acc_ff <= sq_in;
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= curve_pass_ff ? S_SHIFT : S_LOGI;
            end
            S_LOGI: begin
               e_ff     <= 20'(acc_ff >> (5'd17 - 5'(eip_ff)));
               acc_ff   <= m_in;
               lres_ff  <= 20'(n_in) << 16;
               cnt_ff   <= '0;
               state_ff <= S_LOG;
            end
            S_LOG: begin
               if (sq_in[31]) begin
                  acc_ff           <= sq_in >> 1;
                  lres_ff[~cnt_ff] <= 1'b1;
               end else begin
                  acc_ff <= sq_in;
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_PMUL;
            end
            S_PMUL: begin
               acc_ff <= Q30_ONE;
               if (p_in[15:0] == 16'd0) begin
                  sh_ff    <= 7'(30 - LB) + pn_in;
                  state_ff <= S_SHIFT;
               end else begin
                  sh_ff         <= 7'(30 - LB + 1) + pn_in;
                  efrac_ff      <= 16'd0 - p_in[15:0];
                  cnt_ff        <= '0;
                  curve_pass_ff <= 1'b1;
                  state_ff      <= S_EXP;
               end
            end
            S_SHIFT: begin
               c_ff     <= (shifted_in > 32'(ONE)) ? ONE : shifted_in[LB:0];
               state_ff <= S_BLEND;
            end
            S_BLEND: begin
               out_ff <= out_in;
               if (attack_ff) attack_end_ff <= out_in;
               else decay_end_ff <= out_in;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // advance only when the output register is free
               if (rsp_load_in) begin
                  rsp_cv_level_ff <= out_ff;
                  rsp_phase_ff    <= ph_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: bench/tb.sv
// Self-checking bench for attack_decay_envelope_top: random-gap driver and
// monitor, a bit-true envelope predictor and phased register settings.
// Depends on ade_pkg for register and phase codes.
module tb;

   typedef struct packed {
      logic        gate;
      logic [31:0] now_ms;
   } update_word_type;

   typedef struct packed {
      logic [15:0] cv_level;
      logic [1:0]  phase;
   } level_word_type;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned DRAIN_CYCLES = 120;

   // 2^(2^-(i+1)) in Q30
   localparam logic [31:0] ROOT_Q30 [16] = '{
      32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280439,
      32'd1097253708, 32'd1085434104, 32'd1079572136, 32'd1076653033,
      32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
      32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181};

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_gate = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_cv_level;
   logic [1:0]  rsp_phase;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   attack_decay_envelope_top uut (.*);

   // predictor copy of registers and envelope state
   logic [15:0] peak_q, attack_q, decay_q;
   logic [8:0]  attack_shape_q, decay_shape_q;
   logic        gate_q = 1'b0;
   logic [31:0] start_q = '0;
   logic [15:0] attack_end_q = '0;
   logic [15:0] decay_end_q = '0;
   logic [15:0] level_q = '0;

   update_word_type pending_updates[$];
   level_word_type  expected_levels[$];
   int unsigned  errors = 0;
   int unsigned  updates_sent = 0;
   int unsigned  levels_seen = 0;
   int unsigned  settings_run = 0;
   int unsigned  cycle_count = 0;
   logic [31:0]  clock_ms;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] exp2_frac(input logic [15:0] f);
      logic [63:0] r;
      r = 64'd1 << 30;
      for (int i = 0; i < 16; i++)
         if (f[15-i]) r = (r * ROOT_Q30[i]) >> 30;
      return r;
   endfunction

   function automatic logic [31:0] log2_fix(input logic [31:0] x);
      logic [31:0] n, res;
      logic [63:0] m;
      n = 0;
      if (x == 0) return 0;
      while (n < 31 && (x >> (n + 1)) != 0) n++;
      m = {32'd0, x} << (30 - n);
      res = n << 16;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            res[15-i] = 1'b1;
         end
      end
      return res;
   endfunction

   // (k/D)^e in Q0.16, shape 128 exact linear
   function automatic logic [63:0] shaped_curve(input logic [63:0] k,
                                                input logic [8:0] shape_in);
      logic [31:0] s, y, ld, lk, n, f, sh;
      logic [63:0] e, lg, p, v, r;
      s = (shape_in > 256) ? 32'd256 : {23'd0, shape_in};
      if (k >= ade_pkg::CURVE_TABLE_DEPTH) return 64'd1 << 16;
      if (k == 0) return 0;
      if (s == 128) return (k << 16) / ade_pkg::CURVE_TABLE_DEPTH;
      y = (s * 32'd94548) / 32'd64 - 32'd189096 + (32'd3 << 16);
      e = exp2_frac(y[15:0]) >> (17 - y[31:16]);
      ld = log2_fix(ade_pkg::CURVE_TABLE_DEPTH);
      lk = log2_fix(k[31:0]);
      lg = (ld > lk) ? {32'd0, ld - lk} : 64'd0;
      p = (e * lg) >> 16;
      n = ((p >> 16) > 64) ? 32'd64 : p[47:16];
      f = {16'd0, p[15:0]};
      if (f == 0) begin
         v = 64'd1 << 30;
         sh = 14 + n;
      end else begin
         v = exp2_frac(16'(32'd65536 - f));
         sh = 15 + n;
      end
      r = (sh >= 64) ? 64'd0 : (v >> sh);
      return (r > (64'd1 << 16)) ? (64'd1 << 16) : r;
   endfunction

   function automatic logic [63:0] segment_curve(input logic [31:0] elapsed,
                                                input logic [15:0] span,
                                                input logic [8:0] shape_in);
      if (span == 0) return 64'd1 << 16;
      return shaped_curve(({32'd0, elapsed} * ade_pkg::CURVE_TABLE_DEPTH) / span,
                          shape_in);
   endfunction

   // advance the envelope state by one update and return the level word
   function automatic level_word_type envelope_update(input update_word_type u);
      level_word_type w;
      logic [31:0] elapsed;
      logic [63:0] c, d;
      if (u.gate && !gate_q) begin
         gate_q = 1'b1;
         start_q = u.now_ms;
      end else if (!u.gate && gate_q) begin
         gate_q = 1'b0;
         start_q = u.now_ms;
      end
      elapsed = u.now_ms - start_q;
      if (gate_q) begin
         if (elapsed <= attack_q) begin
            c = segment_curve(elapsed, attack_q, attack_shape_q);
            if (peak_q >= decay_end_q) begin
               d = ({48'd0, peak_q - decay_end_q} * c) >> 16;
               level_q = decay_end_q + d[15:0];
            end else begin
               d = ({48'd0, decay_end_q - peak_q} * c) >> 16;
               level_q = decay_end_q - d[15:0];
            end
            attack_end_q = level_q;
            w.phase = ade_pkg::PH_ATTACK;
         end else begin
            w.phase = ade_pkg::PH_HOLD;
         end
      end else begin
         if (elapsed <= decay_q) begin
            c = segment_curve(elapsed, decay_q, decay_shape_q);
            d = ({48'd0, attack_end_q} * c) >> 16;
            level_q = attack_end_q - d[15:0];
            decay_end_q = level_q;
            w.phase = ade_pkg::PH_DECAY;
         end else begin
            w.phase = ade_pkg::PH_REST;
         end
      end
      w.cv_level = level_q;
      return w;
   endfunction

   // mostly short gaps, a few long ones, and gap-free stretches
   function automatic int unsigned pick_gap(input logic steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 45);
   endfunction

   // ---------------- driver: hold each word until accepted ----------------
   logic        req_taken = 1'b0;
   int unsigned req_gap = 0;
   logic        req_steady = 1'b0;

   always @(negedge clock) begin
      logic       next_valid;
      update_word_type w;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         if (($urandom_range(0, 99)) == 0) req_steady <= ~req_steady;
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            next_valid = 1'b0;
         end else if (pending_updates.size() > 0) begin
            w = pending_updates.pop_front();
            req_gate <= w.gate;
            req_now_ms <= w.now_ms;
            next_valid = 1'b1;
            req_gap <= pick_gap(req_steady);
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
   end

   // predict at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_levels.push_back(envelope_update('{gate: req_gate, now_ms: req_now_ms}));
         updates_sent++;
      end
      req_taken <= !reset && req_valid && req_ready;
   end

   // ---------------- monitor: random back-pressure and compare ------------
   int unsigned rsp_stall = 0;
   logic        rsp_steady = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (($urandom_range(0, 99)) == 0) rsp_steady <= ~rsp_steady;
         rsp_ready <= 1'b1;
         rsp_stall <= pick_gap(rsp_steady);
      end
   end

   always @(posedge clock) begin
      level_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         levels_seen++;
         if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t: unexpected level word cv=%h phase=%0d", $time,
                     rsp_cv_level, rsp_phase);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_cv_level !== want.cv_level) begin
               errors++;
               $display("%0t: cv_level expected %h actual %h", $time,
                        want.cv_level, rsp_cv_level);
            end
            if (rsp_phase !== want.phase) begin
               errors++;
               $display("%0t: phase expected %0d actual %0d", $time,
                        want.phase, rsp_phase);
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- sequencing ----------------
   task automatic push_update(input logic g, input logic [31:0] t);
      pending_updates.push_back('{gate: g, now_ms: t});
   endtask

   // wait for every word to drain, then let the block settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_updates.size() > 0 || req_valid || expected_levels.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         ade_pkg::CSR_PEAK_LEVEL:   peak_q = value;
         ade_pkg::CSR_ATTACK_MS:    attack_q = value;
         ade_pkg::CSR_ATTACK_SHAPE: attack_shape_q = value[8:0];
         ade_pkg::CSR_DECAY_MS:     decay_q = value;
         ade_pkg::CSR_DECAY_SHAPE:  decay_shape_q = value[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic [15:0] pk, input logic [15:0] am,
                                input logic [15:0] ash, input logic [15:0] dm,
                                input logic [15:0] dsh);
      wait_quiet();
      write_reg(ade_pkg::CSR_PEAK_LEVEL, pk);
      write_reg(ade_pkg::CSR_ATTACK_MS, am);
      write_reg(ade_pkg::CSR_ATTACK_SHAPE, ash);
      write_reg(ade_pkg::CSR_DECAY_MS, dm);
      write_reg(ade_pkg::CSR_DECAY_SHAPE, dsh);
      settings_run++;
   endtask

   function automatic logic [31:0] time_step(input logic [15:0] span);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 32'(span) + 40);
      return $urandom_range(0, 32'(span) / 6 + 3);
   endfunction

   // gate pulses with random timing, plus some noise words
   task automatic random_burst(input int unsigned count);
      int unsigned left;
      int unsigned len;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 12) begin
            push_update(1'($urandom_range(0, 1)), $urandom());
            left--;
         end else begin
            if ($urandom_range(0, 19) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
            len = $urandom_range(1, 10);
            for (int i = 0; i < len && left > 0; i++) begin
               clock_ms += time_step(attack_q);
               push_update(1'b1, clock_ms);
               left--;
            end
            len = $urandom_range(1, 10);
            for (int i = 0; i < len && left > 0; i++) begin
               clock_ms += time_step(decay_q);
               push_update(1'b0, clock_ms);
               left--;
            end
         end
      end
   endtask

   initial begin
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      peak_q = 16'd65535;
      attack_q = 16'd100;
      attack_shape_q = 9'd128;
      decay_q = 16'd100;
      decay_shape_q = 9'd128;
      clock_ms = 32'd1000;

      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // decay from zero after reset, then rest
      push_update(1'b0, 32'd0);
      push_update(1'b0, 32'd100);
      push_update(1'b0, 32'd101);
      // attack across the time wrap, its end point, then hold
      push_update(1'b1, 32'hFFFF_FFF0);
      push_update(1'b1, 32'h0000_0010);
      push_update(1'b1, 32'h0000_0054);
      push_update(1'b1, 32'h0000_0055);
      push_update(1'b1, 32'hFFFF_FFFF);
      // decay part way, end, rest
      push_update(1'b0, 32'd500);
      push_update(1'b0, 32'd550);
      push_update(1'b0, 32'd600);
      push_update(1'b0, 32'd601);

      // zero phase times jump straight to the end; peak level of zero
      apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd256);
      push_update(1'b1, 32'd10);
      push_update(1'b1, 32'd10);
      push_update(1'b1, 32'd11);
      push_update(1'b0, 32'd20);
      push_update(1'b0, 32'd21);

      // steepest shape and an out-of-range shape clamped to it, dropped indexes
      apply_setting(16'd65535, 16'd65535, 16'd256, 16'd65535, 16'h01FF);
      write_reg(3'd5, 16'hFFFF);
      write_reg(3'd7, 16'h0000);
      push_update(1'b1, 32'd0);
      push_update(1'b1, 32'd1);
      push_update(1'b1, 32'd32768);
      push_update(1'b0, 32'd40000);
      push_update(1'b0, 32'd40001);
      push_update(1'b0, 32'd70000);
      push_update(1'b1, 32'd70000);

      apply_setting(16'd65535, 16'd100, 16'd128, 16'd100, 16'd128);
      random_burst(260);
      apply_setting(16'd40000, 16'd50, 16'd0, 16'd30, 16'd256);
      random_burst(260);
      apply_setting(16'd1, 16'd1, 16'd300, 16'd1, 16'd0);
      random_burst(200);
      apply_setting(16'd65535, 16'd65535, 16'd64, 16'd65535, 16'd200);
      random_burst(200);
      apply_setting(16'd0, 16'd255, 16'd256, 16'd0, 16'd127);
      random_burst(200);
      for (int p = 0; p < 4; p++) begin
         apply_setting(16'($urandom()), 16'($urandom_range(0, 400)),
                       16'($urandom_range(0, 511)), 16'($urandom_range(0, 400)),
                       16'($urandom_range(0, 511)));
         random_burst(180);
      end

      wait_quiet();
      $display("Covered %0d updates, %0d level words over %0d register settings,",
               updates_sent, levels_seen, settings_run);
      $display("including zero spans, extreme shapes, time wrap and noise words.");
      if (errors == 0 && expected_levels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
